// ===== src/kc_pkg.sv =====
// kc_pkg: shared types, codes and the segment table for the keypad calculator.
// No dependencies; compiled first.
`default_nettype none

package kc_pkg;

	localparam logic [15:0] HOLDOFF_RESET = 16'd3;

	localparam logic [3:0] KEY_ADD = 4'd10;
	localparam logic [3:0] KEY_SUB = 4'd11;
	localparam logic [3:0] KEY_MUL = 4'd12;
	localparam logic [3:0] KEY_DIV = 4'd13;
	localparam logic [3:0] KEY_EQ  = 4'd14;

	localparam logic [3:0] SEL_D3 = 4'h8;
	localparam logic [3:0] SEL_D2 = 4'h4;
	localparam logic [3:0] SEL_D1 = 4'h2;
	localparam logic [3:0] SEL_D0 = 4'h1;

	localparam int unsigned OPND_W     = 7;
	localparam int unsigned RES_W      = 14;
	localparam int unsigned DIV_STEPS  = OPND_W;
	localparam int unsigned CONV_STEPS = RES_W;
	localparam int unsigned CNT_W      = 4;

	typedef enum logic [2:0] {
		SC_FIRST_HI  = 3'd0,
		SC_FIRST_LO  = 3'd1,
		SC_SECOND_HI = 3'd2,
		SC_SECOND_LO = 3'd3,
		SC_RES_A     = 3'd4,
		SC_RES_B     = 3'd5,
		SC_RES_C     = 3'd6,
		SC_RES_D     = 3'd7
	} scan_t;

	typedef struct packed {
		logic       dig_we;
		logic [1:0] dig_idx;
		logic       load_first;
		logic       clr_ops;
		logic       clr_res;
		logic       scan_set;
		scan_t      scan_val;
		logic       hold_reload;
		logic       hold_step;
		logic       calc;
		logic       div_step;
		logic       conv_step;
		logic       emit;
	} kc_cmd_t;

	typedef struct packed {
		logic hold_zero;
		logic div_run;
		logic div_last;
		logic conv_last;
	} kc_stat_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'hFC;
			4'd1: s = 8'h60;
			4'd2: s = 8'hDA;
			4'd3: s = 8'hF2;
			4'd4: s = 8'h66;
			4'd5: s = 8'hB6;
			4'd6: s = 8'hBE;
			4'd7: s = 8'hE0;
			4'd8: s = 8'hFE;
			4'd9: s = 8'hE6;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== src/kc_if.sv =====
// kc_if: valid/ready channel interfaces for key input and display output.
// Depends on nothing; used by the top level.
`default_nettype none

interface key_if;
	logic       valid;
	logic       ready;
	logic       key_valid;
	logic [3:0] key_code;

	modport source (output valid, output key_valid, output key_code, input ready);
	modport sink (input valid, input key_valid, input key_code, output ready);
endinterface

interface disp_if;
	logic       valid;
	logic       ready;
	logic [7:0] segments;
	logic [3:0] digit_select;

	modport source (output valid, output segments, output digit_select, input ready);
	modport sink (input valid, input segments, input digit_select, output ready);
endinterface

`default_nettype wire

// ===== src/kc_dp.sv =====
// kc_dp: calculator datapath - operand/result storage, hold-off counter,
// iterative divider, double-dabble conversion and display scan. Uses kc_pkg.
`default_nettype none

module kc_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_wdata,
	input  wire logic [3:0]         key_code,
	input  wire kc_pkg::kc_cmd_t    cmd,
	output      kc_pkg::kc_stat_t   stat,
	output      logic [7:0]         segments,
	output      logic [3:0]         digit_select
);
	import kc_pkg::*;

	logic [15:0]       holdoff_q;
	logic [15:0]       hold_cnt_q;
	logic [3:0]        dig_q [4];
	logic [OPND_W-1:0] first_q;
	logic [3:0]        op_q;
	logic [15:0]       res_q;
	logic              neg_q;
	scan_t             scan_q;
	logic [RES_W-1:0]  w_q;
	logic [OPND_W-1:0] dq_q;
	logic [OPND_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [7:0]        seg_q;
	logic [3:0]        sel_q;

	logic [15:0]       hold_nx;
	logic [OPND_W-1:0] b_val;
	logic [OPND_W-1:0] first_nx;
	logic [RES_W-1:0]  calc_r;
	logic              calc_neg;
	logic [OPND_W:0]   rem_sh;
	logic              rem_ge;
	logic [OPND_W-1:0] rem_nx;
	logic [OPND_W-1:0] dq_nx;
	logic [15:0]       bcd_adj;
	logic [3:0]        disp_d;
	logic [7:0]        disp_seg;
	logic [3:0]        disp_sel;
	scan_t             scan_nx;

	assign hold_nx  = cmd.hold_reload ? holdoff_q : hold_cnt_q;
	assign b_val    = {dig_q[2], 3'b000} + {2'b00, dig_q[2], 1'b0} + {3'b000, dig_q[3]};
	assign first_nx = {dig_q[0], 3'b000} + {2'b00, dig_q[0], 1'b0} + {3'b000, dig_q[1]};

	assign stat.hold_zero = (hold_cnt_q == 16'd0);
	assign stat.div_run   = (op_q == KEY_DIV) && (b_val != '0);
	assign stat.div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign stat.conv_last = (cnt_q == CNT_W'(CONV_STEPS - 1));

	always_comb begin
		calc_r   = '0;
		calc_neg = 1'b0;
		case (op_q)
			KEY_ADD: calc_r = RES_W'(first_q) + RES_W'(b_val);
			KEY_SUB: begin
				if (first_q >= b_val) begin
					calc_r = RES_W'(first_q - b_val);
				end else begin
					calc_r   = RES_W'(b_val - first_q);
					calc_neg = 1'b1;
				end
			end
			KEY_MUL: calc_r = RES_W'(first_q) * RES_W'(b_val);
			default: calc_r = '0;
		endcase
	end

	// restoring divide, one quotient bit a step
	assign rem_sh = {rem_q, dq_q[OPND_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, b_val});
	assign rem_nx = rem_ge ? OPND_W'(rem_sh - {1'b0, b_val}) : rem_sh[OPND_W-1:0];
	assign dq_nx  = {dq_q[OPND_W-2:0], rem_ge};

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			bcd_adj[i*4 +: 4] = (res_q[i*4 +: 4] >= 4'd5) ? res_q[i*4 +: 4] + 4'd3
			                                             : res_q[i*4 +: 4];
		end
	end

	always_comb begin
		disp_d   = res_q[3:0];
		disp_sel = SEL_D0;
		scan_nx  = SC_RES_A;
		case (scan_q)
			SC_FIRST_HI:  begin disp_d = dig_q[0];     disp_sel = SEL_D1; scan_nx = SC_FIRST_LO;  end
			SC_FIRST_LO:  begin disp_d = dig_q[1];     disp_sel = SEL_D0; scan_nx = SC_FIRST_HI;  end
			SC_SECOND_HI: begin disp_d = dig_q[2];     disp_sel = SEL_D1; scan_nx = SC_SECOND_LO; end
			SC_SECOND_LO: begin disp_d = dig_q[3];     disp_sel = SEL_D0; scan_nx = SC_SECOND_HI; end
			SC_RES_A:     begin disp_d = res_q[15:12]; disp_sel = SEL_D3; scan_nx = SC_RES_B;     end
			SC_RES_B:     begin disp_d = res_q[11:8];  disp_sel = SEL_D2; scan_nx = SC_RES_C;     end
			SC_RES_C:     begin disp_d = res_q[7:4];   disp_sel = SEL_D1; scan_nx = SC_RES_D;     end
			default:      begin disp_d = res_q[3:0];   disp_sel = SEL_D0; scan_nx = SC_RES_A;     end
		endcase
		disp_seg = seg_of(disp_d);
		if (scan_q == SC_RES_A && neg_q) begin
			disp_seg = disp_seg + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q  <= HOLDOFF_RESET;
			hold_cnt_q <= '0;
			for (int i = 0; i < 4; i++) dig_q[i] <= '0;
			first_q    <= '0;
			op_q       <= '0;
			res_q      <= '0;
			neg_q      <= 1'b0;
			scan_q     <= SC_FIRST_HI;
		end else begin
			if (cfg_we) holdoff_q <= cfg_wdata;
			if (cmd.hold_step) hold_cnt_q <= (hold_nx != 16'd0) ? hold_nx - 16'd1 : 16'd0;
			if (cmd.dig_we) dig_q[cmd.dig_idx] <= key_code;
			if (cmd.load_first) begin
				first_q <= first_nx;
				op_q    <= key_code;
			end
			if (cmd.clr_ops) begin
				for (int i = 0; i < 4; i++) dig_q[i] <= '0;
				first_q <= '0;
			end
			if (cmd.clr_res) begin
				res_q <= '0;
				neg_q <= 1'b0;
			end
			if (cmd.calc) begin
				res_q <= '0;
				neg_q <= neg_q | calc_neg;
			end
			if (cmd.conv_step) res_q <= {bcd_adj[14:0], w_q[RES_W-1]};
			if (cmd.scan_set) scan_q <= cmd.scan_val;
			if (cmd.emit) scan_q <= scan_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			w_q   <= calc_r;
			dq_q  <= first_q;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			dq_q  <= dq_nx;
			rem_q <= rem_nx;
			if (stat.div_last) begin
				w_q   <= RES_W'(dq_nx);
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
		if (cmd.conv_step) begin
			w_q   <= {w_q[RES_W-2:0], 1'b0};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.emit) begin
			seg_q <= disp_seg;
			sel_q <= disp_sel;
		end
	end

	assign segments     = seg_q;
	assign digit_select = sel_q;

endmodule

`default_nettype wire

// ===== src/kc_ctrl.sv =====
// kc_ctrl: item sequencer and key-entry state machine; drives kc_dp by command
// struct and reads its status. Uses kc_pkg.
`default_nettype none

module kc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_key_valid,
	input  wire logic [3:0]        in_key_code,
	output      logic              in_ready,
	input  wire logic              out_ready,
	output      logic              out_valid,
	input  wire kc_pkg::kc_stat_t  stat,
	output      kc_pkg::kc_cmd_t   cmd
);
	import kc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CALC = 5'b00010,
		S_DIV  = 5'b00100,
		S_CONV = 5'b01000,
		S_OUT  = 5'b10000
	} seq_t;

	typedef enum logic [8:0] {
		PH_FIRST_HI     = 9'b000000001,
		PH_FIRST_LO     = 9'b000000010,
		PH_FIRST_AGAIN  = 9'b000000100,
		PH_SECOND_HI    = 9'b000001000,
		PH_SECOND_LO    = 9'b000010000,
		PH_SECOND_AGAIN = 9'b000100000,
		PH_RESULT_INIT  = 9'b001000000,
		PH_RESULT_SHOW  = 9'b010000000,
		PH_RESTART      = 9'b100000000
	} phase_t;

	seq_t   state_q, state_d;
	phase_t phase_q, phase_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;
	logic   is_op;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign is_op     = (in_key_code >= KEY_ADD);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		phase_d = phase_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.hold_step = 1'b1;
					state_d       = S_OUT;
					if (stat.hold_zero) begin
						unique case (phase_q) inside
							PH_FIRST_HI, PH_FIRST_LO, PH_FIRST_AGAIN: begin
								if (in_key_valid) begin
									if (is_op) begin
										if (phase_q != PH_FIRST_HI) begin
											cmd.load_first  = 1'b1;
											cmd.scan_set    = 1'b1;
											cmd.scan_val    = SC_SECOND_HI;
											cmd.hold_reload = 1'b1;
											phase_d         = PH_SECOND_HI;
										end
									end else if (phase_q == PH_FIRST_LO) begin
										cmd.dig_we      = 1'b1;
										cmd.dig_idx     = 2'd1;
										cmd.hold_reload = 1'b1;
										phase_d         = PH_FIRST_AGAIN;
									end else begin
										cmd.dig_we      = 1'b1;
										cmd.dig_idx     = 2'd0;
										cmd.hold_reload = 1'b1;
										phase_d         = PH_FIRST_LO;
									end
								end
							end
							PH_SECOND_HI, PH_SECOND_LO, PH_SECOND_AGAIN: begin
								if (in_key_valid) begin
									if (is_op) begin
										if (phase_q != PH_SECOND_HI && in_key_code == KEY_EQ) begin
											cmd.scan_set    = 1'b1;
											cmd.scan_val    = SC_RES_A;
											cmd.hold_reload = 1'b1;
											phase_d         = PH_RESULT_INIT;
											state_d         = S_CALC;
										end
									end else if (phase_q == PH_SECOND_LO) begin
										cmd.dig_we      = 1'b1;
										cmd.dig_idx     = 2'd3;
										cmd.hold_reload = 1'b1;
										phase_d         = PH_SECOND_AGAIN;
									end else begin
										cmd.dig_we      = 1'b1;
										cmd.dig_idx     = 2'd2;
										cmd.hold_reload = 1'b1;
										phase_d         = PH_SECOND_LO;
									end
								end
							end
							PH_RESULT_INIT: begin
								cmd.clr_ops = 1'b1;
								phase_d     = PH_RESULT_SHOW;
								if (in_key_valid) begin
									cmd.hold_reload = 1'b1;
									phase_d         = PH_RESTART;
								end
							end
							PH_RESULT_SHOW: begin
								if (in_key_valid) begin
									cmd.hold_reload = 1'b1;
									phase_d         = PH_RESTART;
								end
							end
							default: begin
								cmd.clr_res  = 1'b1;
								cmd.scan_set = 1'b1;
								cmd.scan_val = SC_FIRST_HI;
								phase_d      = PH_FIRST_HI;
							end
						endcase
					end
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = stat.div_run ? S_DIV : S_CONV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = S_CONV;
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (stat.conv_last) state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_FIRST_HI;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted item did not start work");

	a_calc_after_equals: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CALC |-> $past(state_q == S_IDLE) && phase_q == PH_RESULT_INIT)
		else $error("compute entered without an equals key");

	a_conv_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CONV && stat.conv_last |=> state_q == S_OUT)
		else $error("conversion did not hand over to output");

	a_reload_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hold_reload |-> stat.hold_zero)
		else $error("key taken during hold-off");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result written over a pending transfer");

endmodule

`default_nettype wire

// ===== src/keypad_calculator_display.sv =====
// keypad_calculator_display: top level joining kc_ctrl and kc_dp to the key
// and display channels. Depends on kc_pkg, kc_if, kc_ctrl, kc_dp.
//
//  channel  dir  handshake      payload
//  key      in   valid/ready    key_valid[0], key_code[3:0]
//  disp     out  valid/ready    segments[7:0], digit_select[3:0]
//  cfg      in   cfg_we         cfg_wdata[15:0] (key_holdoff)
//
// One key transfer in, one display transfer out; items handled one at a time.
// Plain items go straight to output; an equals key first runs 1 compute, 7
// divide steps for division, 14 double-dabble steps in the shared converter.
// A display transfer stalled by the sink holds the next item in the output
// state; key ready is low until then. Reset is asynchronous; no clearing pass.
`default_nettype none

module keypad_calculator_display (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	key_if.sink              key,
	disp_if.source           disp
);
	import kc_pkg::*;

	kc_cmd_t  cmd;
	kc_stat_t stat;

	kc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (key.valid),
		.in_key_valid (key.key_valid),
		.in_key_code  (key.key_code),
		.in_ready     (key.ready),
		.out_ready    (disp.ready),
		.out_valid    (disp.valid),
		.stat         (stat),
		.cmd          (cmd)
	);

	kc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.key_code     (key.key_code),
		.cmd          (cmd),
		.stat         (stat),
		.segments     (disp.segments),
		.digit_select (disp.digit_select)
	);

endmodule

`default_nettype wire
